/* rtl/rhc_pkg.sv */
// Shared definitions for the RGB to HSV converter: channel select codes
// and the status flags that travel down the pipeline beside the data.
// No dependencies.
package rhc_pkg;

  // Which input channel holds the largest value.
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // Hue divisor is six times the chroma: one sextant per primary/secondary.
  localparam int unsigned HUE_SEXTANTS = 6;

  // Per-pixel status that rides beside the payload.
  typedef struct packed {
    logic vld;    // a pixel occupies this stage
    logic gray;   // chroma is zero, hue forced to zero
    logic black;  // value is zero, saturation forced to zero
  } rhc_flags_t;

endpackage

/* rtl/rgb_to_hsv_converter_core.sv */
// Top level of the RGB to HSV converter: front end, two pipelined dividers
// and the output register.
// Depends on rhc_pkg, rhc_prep and rhc_div.
//
//   channel  | ports                                     | transfer when
//   ---------+-------------------------------------------+----------------------------
//   input    | start, busy, in_red, in_green, in_blue    | start high and busy low
//   result   | out_strobe, out_hue, out_saturation,      | out_strobe high (one cycle,
//            | out_brightness                            | cannot be held off)
//
// The block takes one pixel every clock cycle; busy is always low.
// Each result passes through the front end, the divider stages and the
// output register. The two restoring dividers retire one quotient bit per
// register stage. Reset is synchronous and clears only the valid bits of
// the pipeline; no result is strobed until a pixel has gone all the way
// through.
module rgb_to_hsv_converter_core #(
  parameter int COLOR_BITS = 8,
  parameter int HUE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COLOR_BITS-1:0] in_red,
  input  logic [COLOR_BITS-1:0] in_green,
  input  logic [COLOR_BITS-1:0] in_blue,
  output logic                  out_strobe,
  output logic [HUE_BITS-1:0]   out_hue,
  output logic [COLOR_BITS-1:0] out_saturation,
  output logic [COLOR_BITS-1:0] out_brightness
);

  localparam int CB = COLOR_BITS;
  // Both dividers get the same depth so their results leave together.
  localparam int DIV_STAGES = (HUE_BITS > COLOR_BITS) ? HUE_BITS : COLOR_BITS;

  // The pipeline never stalls, so a transfer happens whenever start is high.
  assign busy = 1'b0;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // Front end: max, min and chroma, then dividends and divisors.
  rhc_pkg::rhc_flags_t prep_flags;
  logic [CB+2:0]       hue_rem, hue_den;
  logic [CB:0]         sat_hi, sat_den;
  logic [CB-1:0]       sat_lo, value;

  rhc_prep #(
    .COLOR_BITS (COLOR_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_xfer),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .flags    (prep_flags),
    .hue_rem  (hue_rem),
    .hue_den  (hue_den),
    .sat_hi   (sat_hi),
    .sat_lo   (sat_lo),
    .sat_den  (sat_den),
    .value    (value)
  );

  // Hue divider: the numerator is already below 6c, so the quotient is the
  // fraction n / 6c worked out to HUE_BITS bits with zeros shifted in.
  logic                hue_vld;
  logic [HUE_BITS-1:0] hue_quo;
  logic                hue_gray;

  rhc_div #(
    .DEN_W  (CB + 3),
    .Q_BITS (HUE_BITS),
    .STAGES (DIV_STAGES),
    .TAG_W  (1)
  ) u_hue_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (prep_flags.vld),
    .in_rem  (hue_rem),
    .in_den  (hue_den),
    .in_low  ('0),
    .in_tag  (prep_flags.gray),
    .out_vld (hue_vld),
    .out_quo (hue_quo),
    .out_tag (hue_gray)
  );

  // Saturation divider: (2c(2^CB-1) + v) / 2v, which rounds c(2^CB-1)/v
  // half up. The quotient fits CB bits because c never exceeds v. The value
  // and the black flag ride along as the tag.
  logic          sat_vld;
  logic [CB-1:0] sat_quo;
  logic [CB:0]   sat_tag;

  rhc_div #(
    .DEN_W  (CB + 1),
    .Q_BITS (CB),
    .STAGES (DIV_STAGES),
    .TAG_W  (CB + 1)
  ) u_sat_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (prep_flags.vld),
    .in_rem  (sat_hi),
    .in_den  (sat_den),
    .in_low  (sat_lo),
    .in_tag  ({value, prep_flags.black}),
    .out_vld (sat_vld),
    .out_quo (sat_quo),
    .out_tag (sat_tag)
  );

  // Output register. A gray pixel divides by zero in the hue divider and a
  // black pixel in the saturation divider; those quotients are replaced by
  // zero here.
  logic                strobe_r;
  logic [HUE_BITS-1:0] hue_r;
  logic [CB-1:0]       sat_r, bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= hue_vld && sat_vld;
    end
  end

  always_ff @(posedge clk) begin
    hue_r    <= hue_gray ? '0 : hue_quo;
    sat_r    <= sat_tag[0] ? '0 : sat_quo;
    bright_r <= sat_tag[CB:1];
  end

  assign out_strobe     = strobe_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

endmodule

/* rtl/rhc_prep.sv */
// Front end of the RGB to HSV converter: two register stages that find
// max/min/chroma, then form the hue and saturation dividends and divisors.
// Depends on rhc_pkg.
module rhc_prep #(
  parameter int COLOR_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [COLOR_BITS-1:0]   in_red,
  input  logic [COLOR_BITS-1:0]   in_green,
  input  logic [COLOR_BITS-1:0]   in_blue,
  output rhc_pkg::rhc_flags_t     flags,
  output logic [COLOR_BITS+2:0]   hue_rem,
  output logic [COLOR_BITS+2:0]   hue_den,
  output logic [COLOR_BITS:0]     sat_hi,
  output logic [COLOR_BITS-1:0]   sat_lo,
  output logic [COLOR_BITS:0]     sat_den,
  output logic [COLOR_BITS-1:0]   value
);

  localparam int CB = COLOR_BITS;

  // Stage 1: compare the channels.
  logic [CB-1:0] max_c, min_c;
  logic [1:0]    sel_c;
  logic [CB:0]   diff_c;

  logic          vld1_r;
  logic [CB-1:0] v1_r, c1_r;
  logic [1:0]    sel1_r;
  logic [CB:0]   diff1_r;

  always_comb begin
    if ((in_red >= in_green) && (in_red >= in_blue)) begin
      max_c  = in_red;
      sel_c  = rhc_pkg::SEL_RED;
      diff_c = {1'b0, in_green} - {1'b0, in_blue};
    end else if (in_green >= in_blue) begin
      max_c  = in_green;
      sel_c  = rhc_pkg::SEL_GREEN;
      diff_c = {1'b0, in_blue} - {1'b0, in_red};
    end else begin
      max_c  = in_blue;
      sel_c  = rhc_pkg::SEL_BLUE;
      diff_c = {1'b0, in_red} - {1'b0, in_green};
    end
    if ((in_red <= in_green) && (in_red <= in_blue)) begin
      min_c = in_red;
    end else if (in_green <= in_blue) begin
      min_c = in_green;
    end else begin
      min_c = in_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    v1_r    <= max_c;
    c1_r    <= max_c - min_c;
    sel1_r  <= sel_c;
    diff1_r <= diff_c;
  end

  // Stage 2: build the hue numerator and the saturation dividend.
  // The numerator always lands in [0, 6c), so the sum is kept modulo its width.
  logic [CB+2:0]   c6, base;
  logic [CB+2:0]   num_sum;
  logic [2*CB:0]   sat_num;

  rhc_pkg::rhc_flags_t flags_r;
  logic [CB+2:0]   hue_rem_r, hue_den_r;
  logic [2*CB:0]   sat_num_r;
  logic [CB-1:0]   v2_r;

  always_comb begin
    c6 = ({3'b000, c1_r} << 2) + ({3'b000, c1_r} << 1);
    case (sel1_r)
      rhc_pkg::SEL_RED:   base = diff1_r[CB] ? c6 : '0;
      rhc_pkg::SEL_GREEN: base = {3'b000, c1_r} << 1;
      default:            base = {3'b000, c1_r} << 2;
    endcase
    num_sum = base + {{2{diff1_r[CB]}}, diff1_r};
    // c * (2^CB - 1) * 2 + v, done with shifts.
    sat_num = ({(CB+1)'(0), c1_r} << (CB + 1)) - ({(CB+1)'(0), c1_r} << 1)
              + {(CB+1)'(0), v1_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r.vld <= 1'b0;
    end else begin
      flags_r.vld <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    flags_r.gray  <= (c1_r == '0);
    flags_r.black <= (v1_r == '0);
    hue_rem_r     <= num_sum;
    hue_den_r     <= c6;
    sat_num_r     <= sat_num;
    v2_r          <= v1_r;
  end

  assign flags   = flags_r;
  assign hue_rem = hue_rem_r;
  assign hue_den = hue_den_r;
  assign sat_hi  = sat_num_r[2*CB:CB];
  assign sat_lo  = sat_num_r[CB-1:0];
  assign sat_den = {v2_r, 1'b0};
  assign value   = v2_r;

endmodule

/* rtl/rhc_div.sv */
// Pipelined restoring divider for the RGB to HSV converter: one quotient
// bit per register stage, with valid and tag carried alongside.
// No package dependencies.
module rhc_div #(
  parameter int DEN_W  = 11,
  parameter int Q_BITS = 16,
  parameter int STAGES = 16,
  parameter int TAG_W  = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [DEN_W-1:0]  in_rem,   // must be below in_den
  input  logic [DEN_W-1:0]  in_den,
  input  logic [Q_BITS-1:0] in_low,   // dividend bits shifted in, MSB first
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_vld,
  output logic [Q_BITS-1:0] out_quo,
  output logic [TAG_W-1:0]  out_tag
);

  logic              vld_r [STAGES];
  logic [DEN_W-1:0]  rem_r [STAGES];
  logic [DEN_W-1:0]  den_r [STAGES];
  logic [Q_BITS-1:0] low_r [STAGES];
  logic [Q_BITS-1:0] quo_r [STAGES];
  logic [TAG_W-1:0]  tag_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic              cur_vld;
    logic [DEN_W-1:0]  cur_rem, cur_den;
    logic [Q_BITS-1:0] cur_low, cur_quo;
    logic [TAG_W-1:0]  cur_tag;

    if (k == 0) begin : g_first
      assign cur_vld = in_vld;
      assign cur_rem = in_rem;
      assign cur_den = in_den;
      assign cur_low = in_low;
      assign cur_quo = '0;
      assign cur_tag = in_tag;
    end else begin : g_next
      assign cur_vld = vld_r[k-1];
      assign cur_rem = rem_r[k-1];
      assign cur_den = den_r[k-1];
      assign cur_low = low_r[k-1];
      assign cur_quo = quo_r[k-1];
      assign cur_tag = tag_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= cur_vld;
      end
    end

    if (k < Q_BITS) begin : g_step
      logic [DEN_W:0] trial;
      logic           take;

      assign trial = {cur_rem, cur_low[Q_BITS-1]};
      assign take  = (trial >= {1'b0, cur_den});

      always_ff @(posedge clk) begin
        rem_r[k] <= take ? DEN_W'(trial - {1'b0, cur_den}) : trial[DEN_W-1:0];
        den_r[k] <= cur_den;
        low_r[k] <= cur_low << 1;
        quo_r[k] <= {cur_quo[Q_BITS-2:0], take};
        tag_r[k] <= cur_tag;
      end
    end else begin : g_hold
      // Extra stages only delay, so that dividers of different sizes line up.
      always_ff @(posedge clk) begin
        rem_r[k] <= cur_rem;
        den_r[k] <= cur_den;
        low_r[k] <= cur_low;
        quo_r[k] <= cur_quo;
        tag_r[k] <= cur_tag;
      end
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign out_quo = quo_r[STAGES-1];
  assign out_tag = tag_r[STAGES-1];

endmodule

/* test/rgb_to_hsv_converter_core_test.sv */
// Testbench for rgb_to_hsv_converter_core: drives pixels through the start/busy
// command port and checks every strobed hue, saturation and value result.
// Depends only on the converter RTL (and, through it, rhc_pkg).
module rgb_to_hsv_converter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLOR_BITS = 8;
  localparam int HUE_BITS   = 16;
  localparam int CMAX       = (1 << COLOR_BITS) - 1;
  // Pipeline depth of the converter: one stage per quotient bit of the wider divider plus three.
  localparam int LATENCY    = ((HUE_BITS > COLOR_BITS) ? HUE_BITS : COLOR_BITS) + 3;
  // Cycles to linger after the last result so that a stray strobe is still seen.
  localparam int DRAIN_CYCLES = 2 * LATENCY + 8;
  // Cycles with no transfer on either side before the run is declared hung.
  localparam int HANG_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 1200;

  typedef logic [COLOR_BITS-1:0] chan_t;

  // One expected result, along with the pixel that produced it for messages.
  typedef struct {
    chan_t                 red;
    chan_t                 green;
    chan_t                 blue;
    logic [HUE_BITS-1:0]   hue;
    chan_t                 sat;
    chan_t                 val;
  } hsv_expect_t;

  // A row of the directed table. When has_result is set the hue/sat/val in
  // the row are the expected result; otherwise the predictor supplies it.
  typedef struct packed {
    chan_t               red;
    chan_t               green;
    chan_t               blue;
    logic                has_result;
    logic [HUE_BITS-1:0] hue;
    chan_t               sat;
    chan_t               val;
  } pixel_row_t;

  localparam int DIRECTED_ROWS = 22;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  chan_t                 in_red = '0;
  chan_t                 in_green = '0;
  chan_t                 in_blue = '0;
  logic                  out_strobe;
  logic [HUE_BITS-1:0]   out_hue;
  chan_t                 out_saturation;
  chan_t                 out_brightness;

  // Side band that travels with the pixel being offered: a result typed in
  // from the directed table, if any. Driven together with the data.
  logic                  offer_has_result = 1'b0;
  hsv_expect_t           offer_result;

  hsv_expect_t           hsv_expect_q[$];
  int                    mismatch_count = 0;
  int                    quiet_cycles = 0;

  pixel_row_t            directed_table [DIRECTED_ROWS];

  rgb_to_hsv_converter_core #(
    .COLOR_BITS(COLOR_BITS),
    .HUE_BITS  (HUE_BITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_strobe    (out_strobe),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_brightness(out_brightness)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Exact integer HSV of one pixel. Value is the largest channel and chroma
  // the spread between largest and smallest. The hue numerator is measured
  // from the sextant of the largest channel; ties go to red, then green.
  // Saturation is chroma over value scaled to full scale, rounded half up.
  function automatic hsv_expect_t rgb_to_hsv(chan_t r, chan_t g, chan_t b);
    int unsigned rr, gg, bb, v, m, c, n;
    hsv_expect_t res;
    rr = r;
    gg = g;
    bb = b;
    v = rr;
    if (gg > v) v = gg;
    if (bb > v) v = bb;
    m = rr;
    if (gg < m) m = gg;
    if (bb < m) m = bb;
    c = v - m;
    res.red = r;
    res.green = g;
    res.blue = b;
    res.hue = '0;
    if (c != 0) begin
      if (v == rr) begin
        // Red sector wraps: a negative green-minus-blue lands just below a full turn.
        n = (gg >= bb) ? gg - bb : 6 * c - (bb - gg);
      end else if (v == gg) begin
        n = 2 * c + bb - rr;
      end else begin
        n = 4 * c + rr - gg;
      end
      res.hue = HUE_BITS'((n << HUE_BITS) / (6 * c));
    end
    res.sat = '0;
    if (v != 0) res.sat = COLOR_BITS'((2 * c * CMAX + v) / (2 * v));
    res.val = COLOR_BITS'(v);
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offer one pixel after a random pause bounded by max_gap and return
  // at the clock edge where the transfer happens. With no pause, start is
  // simply left high from the previous pixel.
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                            input logic typed, input hsv_expect_t typed_result,
                            input int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_red           <= r;
    in_green         <= g;
    in_blue          <= b;
    offer_has_result <= typed;
    offer_result     <= typed_result;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Both sides are sampled here at the rising edge, so every read sees the
  // values that were present during the cycle that edge closes. An input
  // transfer pushes its expectation; a strobed result is checked against the
  // oldest one. The push comes first so a pipeline of any depth is handled.
  always @(posedge clk) begin
    hsv_expect_t want;
    logic        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        moved = 1'b1;
        if (offer_has_result) hsv_expect_q.push_back(offer_result);
        else hsv_expect_q.push_back(rgb_to_hsv(in_red, in_green, in_blue));
      end
      if (out_strobe) begin
        moved = 1'b1;
        if (hsv_expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result hue=%0d sat=%0d val=%0d",
                                  out_hue, out_saturation, out_brightness));
        end else begin
          want = hsv_expect_q.pop_front();
          if (out_hue !== want.hue)
            note_mismatch($sformatf("rgb=(%0d,%0d,%0d) hue %0d, expected %0d",
                                    want.red, want.green, want.blue, out_hue, want.hue));
          if (out_saturation !== want.sat)
            note_mismatch($sformatf("rgb=(%0d,%0d,%0d) saturation %0d, expected %0d",
                                    want.red, want.green, want.blue, out_saturation,
                                    want.sat));
          if (out_brightness !== want.val)
            note_mismatch($sformatf("rgb=(%0d,%0d,%0d) brightness %0d, expected %0d",
                                    want.red, want.green, want.blue, out_brightness,
                                    want.val));
        end
      end
    end
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
  end

  // Watchdog: a hung handshake or a lost result stops the run here.
  initial begin
    while (quiet_cycles < HANG_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    hsv_expect_t none;
    hsv_expect_t typed;
    chan_t       r, g, b, peak, low_val;
    int          kind;
    int          max_gap;

    none = '{default: '0};

    // Directed table. The first rows are results that can be read off at a
    // glance: black, white, the primaries at full scale, grays and the
    // smallest nonzero red. The rest go through the predictor: the
    // secondaries (ties for the largest channel), red with green below blue
    // so the hue wraps just short of a full turn, neighbors of each primary
    // hue, a saturation that lands exactly on one half, the smallest
    // chroma at full value and alternating bit patterns.
    directed_table = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, 16'd0,     8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd255, 1'b1, 16'd0,     8'd0,   8'd255},
      '{8'd255, 8'd0,   8'd0,   1'b1, 16'd0,     8'd255, 8'd255},
      '{8'd0,   8'd255, 8'd0,   1'b1, 16'd21845, 8'd255, 8'd255},
      '{8'd0,   8'd0,   8'd255, 1'b1, 16'd43690, 8'd255, 8'd255},
      '{8'd128, 8'd128, 8'd128, 1'b1, 16'd0,     8'd0,   8'd128},
      '{8'd1,   8'd1,   8'd1,   1'b1, 16'd0,     8'd0,   8'd1},
      '{8'd1,   8'd0,   8'd0,   1'b1, 16'd0,     8'd255, 8'd1},
      '{8'd255, 8'd255, 8'd0,   1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd255, 1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd255, 8'd0,   8'd255, 1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd255, 8'd0,   8'd1,   1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd255, 8'd1,   8'd0,   1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd1,   1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd1,   8'd255, 8'd0,   1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd0,   8'd1,   8'd255, 1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd1,   8'd0,   8'd255, 1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd2,   8'd1,   8'd1,   1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd255, 8'd254, 8'd254, 1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd254, 8'd255, 8'd255, 1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd85,  8'd170, 8'd255, 1'b0, 16'd0,     8'd0,   8'd0},
      '{8'd170, 8'd85,  8'd0,   1'b0, 16'd0,     8'd0,   8'd0}
    };

    // Synchronous reset, held from time zero and never asserted again.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_table[i]) begin
      typed = none;
      typed.red   = directed_table[i].red;
      typed.green = directed_table[i].green;
      typed.blue  = directed_table[i].blue;
      typed.hue   = directed_table[i].hue;
      typed.sat   = directed_table[i].sat;
      typed.val   = directed_table[i].val;
      send_pixel(directed_table[i].red, directed_table[i].green, directed_table[i].blue,
                 directed_table[i].has_result, typed, 4);
    end

    // Random pixels. Any channel values are accepted, so every pixel is well formed;
    // the mix leans on the cases where the arithmetic is delicate: grays,
    // ties for the largest or smallest channel, tiny values where rounding
    // and sector boundaries crowd together, and values near both rails.
    max_gap = 4;
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      // Every 40 pixels choose between back-to-back traffic and random pauses.
      if (i % 40 == 0) max_gap = ($urandom_range(0, 2) == 0) ? 0 : 4;
      r = chan_t'($urandom());
      g = chan_t'($urandom());
      b = chan_t'($urandom());
      kind = int'($urandom_range(0, 9));
      case (kind)
        4: begin
          g = r;
          b = r;
        end
        5: begin
          // Two channels share the maximum.
          peak = chan_t'($urandom());
          low_val = chan_t'($urandom_range(0, peak));
          case ($urandom_range(0, 2))
            0: begin r = peak; g = peak; b = low_val; end
            1: begin r = peak; g = low_val; b = peak; end
            default: begin r = low_val; g = peak; b = peak; end
          endcase
        end
        6: begin
          r = chan_t'($urandom_range(0, 3));
          g = chan_t'($urandom_range(0, 3));
          b = chan_t'($urandom_range(0, 3));
        end
        7: begin
          r = $urandom_range(0, 1) ? chan_t'($urandom_range(CMAX - 1, CMAX))
                                   : chan_t'($urandom_range(0, 1));
          g = $urandom_range(0, 1) ? chan_t'($urandom_range(CMAX - 1, CMAX))
                                   : chan_t'($urandom_range(0, 1));
          b = $urandom_range(0, 1) ? chan_t'($urandom_range(CMAX - 1, CMAX))
                                   : chan_t'($urandom_range(0, 1));
        end
        8: begin
          // Two channels are made equal.
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = g;
            default: r = b;
          endcase
        end
        9: begin
          // A single lit channel, or black.
          case ($urandom_range(0, 3))
            0: begin g = '0; b = '0; end
            1: begin r = '0; b = '0; end
            2: begin r = '0; g = '0; end
            default: begin r = '0; g = '0; b = '0; end
          endcase
        end
        default: begin
        end
      endcase
      send_pixel(r, g, b, 1'b0, none, max_gap);
    end
    start <= 1'b0;

    // Let the pipeline empty, then watch a while longer for stray strobes.
    while (hsv_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
